[hw/rtl/hlu_pkg.sv]
// Shared types and character constants for the header line unfolder.
// No dependencies; imported by every module of the block.
package hlu_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Scan phase between successive bytes
	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_CR   = 2'd1,
		PH_CRLF = 2'd2,
		PH_FOLD = 2'd3
	} phase_t;

	// A run of zero to three output bytes, first byte in slot 0
	typedef struct packed {
		logic             load;
		logic [1:0]       cnt;
		logic [2:0][7:0]  bytes;
	} run_t;

endpackage

[hw/rtl/header_line_unfolder.sv]
// Header line unfolder: a CR LF followed by blanks becomes one space, all
// other bytes pass through. One request is taken per cycle while the result
// register can take the held request; each gives zero to three output bytes,
// the last one flagged by tlast. A request that yields two or three bytes holds
// the input side while the result register hands its bytes out one per cycle
// as the output accepts them. The first byte of a request passes through the
// input register and then the result register before it reaches the output.
// Depends on hlu_pkg, hlu_decode and hlu_outbuf.
module header_line_unfolder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tuser,   // req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast    // last_of_run
);
	import hlu_pkg::*;

	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q;
	phase_t     phase_nxt;
	run_t       dec;
	run_t       run;
	logic       free;
	logic       adv;

	// Move the held request into the result register when it can take it
	assign adv      = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	// Input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Advance the scan phase with each decoded request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
		end else if (adv) begin
			phase_q <= phase_nxt;
		end
	end

	hlu_decode u_decode (
		.req_type  (req_s1),
		.in_byte   (byte_s1),
		.phase     (phase_q),
		.run       (dec),
		.phase_nxt (phase_nxt)
	);

	// Load only for a request with at least one byte
	always_comb begin
		run      = dec;
		run.load = adv && (dec.cnt != 2'd0);
	end

	hlu_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (run),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// End of stream always leaves the scan in plain text
	a_flush_text: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1 == REQ_FLUSH) |=> (phase_q == PH_TEXT))
		else $error("flush did not return scan to plain text");

	// A held request must block the input while the result register is busy
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !free) |-> !s_tready)
		else $error("input accepted while request is held");

	// Three-byte runs arise only from CR LF followed by a non-blank
	a_three_crlf: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && dec.cnt == 2'd3) |-> (phase_q == PH_CRLF && req_s1 == REQ_DATA))
		else $error("three-byte run outside CR LF phase");

	// Inside a fold at most one byte is produced
	a_fold_one: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && phase_q == PH_FOLD) |-> (dec.cnt == 2'd0 || dec.cnt == 2'd1))
		else $error("fold produced more than one byte");

endmodule

[hw/rtl/hlu_decode.sv]
// Decode of one request against the current scan phase.
// Produces the output run and the next phase; depends on hlu_pkg.
module hlu_decode (
	input  logic            req_type,
	input  logic [7:0]      in_byte,
	input  hlu_pkg::phase_t phase,
	output hlu_pkg::run_t   run,
	output hlu_pkg::phase_t phase_nxt
);
	import hlu_pkg::*;

	logic blank;

	assign blank = (in_byte == CH_SP) || (in_byte == CH_TAB);

	// Work out the bytes to emit and where the scan goes next
	always_comb begin
		run.load  = 1'b0;
		run.cnt   = 2'd0;
		run.bytes = '0;
		phase_nxt = PH_TEXT;
		if (req_type == REQ_FLUSH) begin
			// flush any pending CR or CR LF
			unique case (phase)
				PH_CR: begin
					run.cnt      = 2'd1;
					run.bytes[0] = CH_CR;
				end
				PH_CRLF: begin
					run.cnt      = 2'd2;
					run.bytes[0] = CH_CR;
					run.bytes[1] = CH_LF;
				end
				default: begin
					run.cnt = 2'd0;
				end
			endcase
		end else begin
			unique case (phase)
				PH_FOLD: begin
					// drop blanks; rescan the first non-blank as plain text
					if (blank) begin
						phase_nxt = PH_FOLD;
					end else if (in_byte == CH_CR) begin
						phase_nxt = PH_CR;
					end else begin
						run.cnt      = 2'd1;
						run.bytes[0] = in_byte;
					end
				end
				PH_CR: begin
					if (in_byte == CH_LF) begin
						phase_nxt = PH_CRLF;
					end else begin
						run.cnt      = 2'd2;
						run.bytes[0] = CH_CR;
						run.bytes[1] = in_byte;
					end
				end
				PH_CRLF: begin
					if (blank) begin
						// fold becomes a single space
						run.cnt      = 2'd1;
						run.bytes[0] = CH_SP;
						phase_nxt    = PH_FOLD;
					end else begin
						run.cnt      = 2'd3;
						run.bytes[0] = CH_CR;
						run.bytes[1] = CH_LF;
						run.bytes[2] = in_byte;
					end
				end
				default: begin
					if (in_byte == CH_CR) begin
						phase_nxt = PH_CR;
					end else begin
						run.cnt      = 2'd1;
						run.bytes[0] = in_byte;
					end
				end
			endcase
		end
	end

endmodule

[hw/rtl/hlu_outbuf.sv]
// Result register that holds one run and hands it out a byte per cycle as m_tready accepts.
// Marks the final byte of each run; depends on hlu_pkg.
module hlu_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  hlu_pkg::run_t run,
	output logic          free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // out_byte
	output logic          m_tlast    // last_of_run
);
	import hlu_pkg::*;

	logic [1:0]      rem_q;
	logic [2:0][7:0] bytes_q;
	logic            take;

	assign take     = m_tvalid && m_tready;
	assign m_tvalid = (rem_q != 2'd0);
	assign m_tlast  = (rem_q == 2'd1);
	assign m_tdata  = bytes_q[0];
	// free when empty, or when the final byte leaves in this cycle
	assign free     = (rem_q == 2'd0) || (m_tlast && m_tready);

	// Track how many bytes of the run remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (run.load && free) begin
			rem_q <= run.cnt;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Load a new run or shift the next byte to the front
	always_ff @(posedge clk) begin
		if (run.load && free) begin
			bytes_q <= run.bytes;
		end else if (take) begin
			bytes_q[0] <= bytes_q[1];
			bytes_q[1] <= bytes_q[2];
		end
	end

endmodule
